// ===== rtl/core/blu_pkg.sv =====
// ----------------------------------------------------------------------------
// blu_pkg
// Shared constants, block kind masks and the item type for the 2x upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package blu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int COORD_W = 10;
  localparam int COL_W   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // size after reset, clamped to the supported range, held as last index
  localparam int RESET_SIZE  = 512;
  localparam int W_RESET_LAST = ((RESET_SIZE > MAX_WIDTH)  ? MAX_WIDTH  : RESET_SIZE) - 1;
  localparam int H_RESET_LAST = ((RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE) - 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // block kinds, in emission order, as one-hot masks
  localparam int NKIND = 4;
  localparam logic [NKIND-1:0] KIND_INNER  = 4'b0001;
  localparam logic [NKIND-1:0] KIND_RIGHT  = 4'b0010;
  localparam logic [NKIND-1:0] KIND_BOTTOM = 4'b0100;
  localparam logic [NKIND-1:0] KIND_CORNER = 4'b1000;

  // result tdata: four pixels, row, col, zero padded to whole bytes
  localparam int OUT_BITS = 4 * PIX_W + 2 * COORD_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_W     = ((PIX_W + 7) / 8) * 8;

  typedef struct packed {
    logic [NKIND-1:0] kinds;  // blocks this pixel completes
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } blu_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/blu_ram.sv =====
// ----------------------------------------------------------------------------
// blu_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // old contents come out when reading and writing the same entry
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/blu_front.sv =====
// ----------------------------------------------------------------------------
// blu_front
// Size registers, raster position, line store read-modify-write, item stage.
// ----------------------------------------------------------------------------
`default_nettype none

module blu_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [blu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [blu_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [blu_pkg::PIX_W-1:0]     in_pixel,
  output logic                               item_valid,
  output blu_pkg::blu_item_t                 item,
  output logic      [blu_pkg::PIX_W-1:0]     up_pixel,
  input  wire logic                          item_retire
);

  import blu_pkg::*;

  logic [COL_W-1:0] wlast_r, wlast_nxt;
  logic [ROW_W-1:0] hlast_r, hlast_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             valid_r, valid_nxt;
  blu_item_t        item_r, item_nxt;
  logic             accept;
  logic             row_end, frame_end;
  logic             cfg_hit;

  assign in_ready = !valid_r || item_retire;
  assign accept   = in_valid && in_ready;
  assign row_end  = (col_r == wlast_r);
  assign frame_end = (row_r == hlast_r);
  assign cfg_hit  = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  // size registers hold last index, clamped to [1, MAX]
  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_we && (cfg_index == REG_WIDTH)) begin
      if (cfg_wdata == '0) begin
        wlast_nxt = '0;
      end else if (32'(cfg_wdata) > MAX_WIDTH) begin
        wlast_nxt = COL_W'(MAX_WIDTH - 1);
      end else begin
        wlast_nxt = COL_W'(cfg_wdata - CFG_W'(1));
      end
    end
    if (cfg_we && (cfg_index == REG_HEIGHT)) begin
      if (cfg_wdata == '0) begin
        hlast_nxt = '0;
      end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
        hlast_nxt = ROW_W'(MAX_HEIGHT - 1);
      end else begin
        hlast_nxt = ROW_W'(cfg_wdata - CFG_W'(1));
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt            = 1'b1;
      item_nxt.pix         = in_pixel;
      item_nxt.col         = col_r;
      item_nxt.row         = row_r;
      item_nxt.kinds       = '0;
      if ((row_r != '0) && (col_r != '0)) item_nxt.kinds = item_nxt.kinds | KIND_INNER;
      if ((row_r != '0) && row_end)       item_nxt.kinds = item_nxt.kinds | KIND_RIGHT;
      if (frame_end && (col_r != '0))     item_nxt.kinds = item_nxt.kinds | KIND_BOTTOM;
      if (frame_end && row_end)           item_nxt.kinds = item_nxt.kinds | KIND_CORNER;
    end else if (item_retire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= COL_W'(W_RESET_LAST);
      hlast_r <= ROW_W'(H_RESET_LAST);
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // line store: fetch the pixel above and replace it in the same access
  blu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .en    (accept),
    .we    (accept),
    .addr  (col_r),
    .wdata (in_pixel),
    .rdata (up_pixel)
  );

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/core/blu_emit.sv =====
// ----------------------------------------------------------------------------
// blu_emit
// Walks the blocks of one item, forms the averages, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blu_emit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      item_valid,
  input  wire blu_pkg::blu_item_t        item,
  input  wire logic [blu_pkg::PIX_W-1:0] up_pixel,
  output logic                           item_retire,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [blu_pkg::OUT_W-1:0] out_data,
  output logic                           out_last
);

  import blu_pkg::*;

  logic [NKIND-1:0] done_r, done_nxt;
  logic [PIX_W-1:0] left_r, upleft_r;
  logic             oval_r, oval_nxt;
  logic [OUT_W-1:0] odata_r;
  logic             olast_r;
  logic [NKIND-1:0] pend, sel;
  logic             slot_free, fire, last;
  logic [PIX_W-1:0] a, b, c, d;
  logic [ROW_W-1:0] brow;
  logic [COL_W-1:0] bcol;
  logic [PIX_W:0]   sum_ab, sum_ac;
  logic [PIX_W+1:0] sum4;
  logic [OUT_W-1:0] blk;

  assign pend      = item.kinds & ~done_r;
  assign sel       = pend & (~pend + NKIND'(1));
  assign slot_free = !oval_r || out_ready;
  assign fire      = item_valid && (pend != '0) && slot_free;
  assign last      = ((pend & ~sel) == '0);
  assign item_retire = item_valid && ((pend == '0) || (fire && last));

  always_comb begin
    a    = item.pix;
    b    = item.pix;
    c    = item.pix;
    d    = item.pix;
    brow = item.row;
    bcol = item.col;
    case (sel)
      KIND_INNER: begin
        a    = upleft_r;
        b    = up_pixel;
        c    = left_r;
        brow = item.row - ROW_W'(1);
        bcol = item.col - COL_W'(1);
      end
      KIND_RIGHT: begin
        a    = up_pixel;
        b    = up_pixel;
        brow = item.row - ROW_W'(1);
      end
      KIND_BOTTOM: begin
        a    = left_r;
        c    = left_r;
        bcol = item.col - COL_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign sum_ab = {1'b0, a} + {1'b0, b};
  assign sum_ac = {1'b0, a} + {1'b0, c};
  assign sum4   = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};

  assign blk = OUT_W'({COORD_W'(bcol), COORD_W'(brow), sum4[PIX_W+1:2],
                       sum_ac[PIX_W:1], sum_ab[PIX_W:1], a});

  always_comb begin
    done_nxt = done_r;
    if (item_retire) begin
      done_nxt = '0;
    end else if (fire) begin
      done_nxt = done_r | sel;
    end
  end

  always_comb begin
    oval_nxt = oval_r;
    if (fire) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r   <= '0;
      oval_r   <= 1'b0;
      left_r   <= '0;
      upleft_r <= '0;
    end else begin
      done_r <= done_nxt;
      oval_r <= oval_nxt;
      if (item_retire) begin
        left_r   <= item.pix;
        upleft_r <= up_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      odata_r <= blk;
      olast_r <= last;
    end
  end

  assign out_valid = oval_r;
  assign out_data  = odata_r;
  assign out_last  = olast_r;

endmodule

`default_nettype wire

// ===== rtl/core/bilinear_upscale_2x.sv =====
// ----------------------------------------------------------------------------
// bilinear_upscale_2x
// One 2x bilinear upscaling stage for 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload
//  -------  ---------  --------------------------------------------------------
//  in_      slave      tdata: pixel
//  out_     master     tdata: four block pixels, source row/col; tlast: last
//  cfg_     write      index 0 image_width, index 1 image_height
//
//  One source pixel per cycle while the item stage retires each pixel at once;
//  a pixel completing one block (or none) retires as soon as that block, if any,
//  is taken. An edge pixel completing 2 to 4 blocks stays in the item stage until
//  the output register, taking one block per cycle while out_tready is high, has
//  taken them all; the next input transfer waits. Each pixel passes the item stage
//  and then the output register before its first block appears on out_tdata.
//  The line store is a single-port RAM, read-first: each pixel fetches the one
//  above and overwrites it in the same access, so no forwarding is needed.
//  Synchronous active-low reset; the line store is not cleared (a write to a
//  size register restarts the frame, so every entry is written before it is used).
//  A stalled out_tready holds the output register; the item stage fills
//  behind it and in_tready drops (pixels completing no block still pass).
//
`default_nettype none

module bilinear_upscale_2x (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [blu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [blu_pkg::CFG_W-1:0]     cfg_wdata,
  // source pixels
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [blu_pkg::IN_W-1:0]      in_tdata,   // [7:0] pixel
  // output blocks
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] top_left, [15:8] top_right, [23:16] bottom_left,
  // [31:24] bottom_right, [41:32] source_row, [51:42] source_col, rest zero
  output logic      [blu_pkg::OUT_W-1:0]     out_tdata,
  output logic                               out_tlast   // last_of_run
);

  import blu_pkg::*;

  // item stage between the line store access and the block walker
  logic             item_valid;
  blu_item_t        item;
  logic [PIX_W-1:0] up_pixel;
  logic             item_retire;

  blu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_pixel    (in_tdata[PIX_W-1:0]),
    .item_valid  (item_valid),
    .item        (item),
    .up_pixel    (up_pixel),
    .item_retire (item_retire)
  );

  // one block per transfer; tlast marks the final block of a source pixel
  blu_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item        (item),
    .up_pixel    (up_pixel),
    .item_retire (item_retire),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/blu_checker.sv =====
// ----------------------------------------------------------------------------
// blu_checker
// Port-level checks on the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module blu_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [blu_pkg::OUT_W-1:0]     out_tdata,
  input wire logic                          out_tlast
);

  import blu_pkg::*;

  // stalled block stays put until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output block changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reset empties the item stage, so a pixel can be taken at once
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // padding above the packed fields is zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >> OUT_BITS) == '0)
    else $error("nonzero padding in output data");

endmodule

bind bilinear_upscale_2x blu_checker u_blu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== bench/bilinear_upscale_2x_tb.sv =====
// ----------------------------------------------------------------------------
// bilinear_upscale_2x_tb
// Self-checking bench for the streaming 2x bilinear upscaler.
// Source pixels go in on a random-gapped stream. A behavioural copy of the
// scaler runs alongside, predicting each 2x2 output block. Every block that
// leaves the design is checked field by field against the oldest prediction.
// The run covers the reset frame size, hand-picked edge frames and clamped
// extreme sizes. It then holds the output off for a long time to back the
// design up, and finishes with random frame sizes and pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_upscale_2x_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blu_pkg::*;

  localparam int CLK_HALF     = 5;       // 10 ns period
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 8;       // margin for a pixel still in flight
  localparam int CYCLE_LIMIT  = 200000;  // run limit; reaching it ends the run as failed
  localparam int HOLD_CYCLES  = 300;     // long output hold-off for the fill test
  localparam int RANDOM_ITEMS = 200;
  localparam int EDGE_ITEMS   = 16;      // pixels per extreme-size frame
  localparam int RESET_ITEMS  = 8;       // pixels at the reset size
  localparam int IDLE_PCT     = 9;
  localparam int MAX_PRINTS   = 30;

  // one predicted 2x2 output block
  typedef struct {
    logic [PIX_W-1:0]   tl;
    logic [PIX_W-1:0]   tr;
    logic [PIX_W-1:0]   bl;
    logic [PIX_W-1:0]   br;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               is_last;
  } upblock_t;

  // --------------------------------------------------------------------------
  // DUT signals: every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tlast;

  bilinear_upscale_2x u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] pixel
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] tl, [15:8] tr, [23:16] bl, [31:24] br,
                               // [41:32] row, [51:42] col, rest zero
    .out_tlast  (out_tlast)    // last block of this pixel
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  upblock_t expected_blocks[$];   // predictions awaiting their output transfer
  int       mismatches     = 0;
  int       pixels_sent    = 0;
  int       blocks_checked = 0;
  int       size_writes    = 0;
  int       cycle_count    = 0;

  // pacing controls, written by the test sequence with nonblocking assignments
  logic     quiet    = 1'b0;     // no idling on either side while set
  int       hold_req = 0;        // bump to start one long output hold-off
  int       hold_ack = 0;
  int       hold_left = 0;

  // --------------------------------------------------------------------------
  // Scaler predictor: own copy of the line store, neighbours, position, sizes
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] upleft_px;
  int               row_pos;
  int               col_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // register value to effective size: zero reads as one, oversize saturates
  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic upblock_t make_block(input int a, input int b, input int c,
                                          input int d, input int r, input int x);
    upblock_t blk;
    blk.tl      = PIX_W'(a);
    blk.tr      = PIX_W'((a + b) / 2);
    blk.bl      = PIX_W'((a + c) / 2);
    blk.br      = PIX_W'((a + b + c + d) / 4);
    blk.row     = COORD_W'(r);
    blk.col     = COORD_W'(x);
    blk.is_last = 1'b0;
    return blk;
  endfunction

  // one accepted source pixel: queue the blocks it completes, in issue order
  function automatic void predict_pixel(input logic [PIX_W-1:0] p);
    int       w;
    int       h;
    int       r;
    int       x;
    int       up;
    upblock_t found[$];
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = row_pos;
    x = col_pos;
    if (x >= w) x = w - 1;
    if (r >= h) r = h - 1;
    up = int'(line_mem[x]);
    // interior block of the pixel up and to the left
    if (r >= 1 && x >= 1) found.push_back(make_block(upleft_px, up, left_px, p, r - 1, x - 1));
    // right column: no right neighbour, replicate across
    if (r >= 1 && x == w - 1) found.push_back(make_block(up, up, p, p, r - 1, x));
    // bottom row: no lower neighbour, replicate down
    if (r == h - 1 && x >= 1) found.push_back(make_block(left_px, p, left_px, p, r, x - 1));
    // bottom-right corner: pixel stands alone
    if (r == h - 1 && x == w - 1) found.push_back(make_block(p, p, p, p, r, x));
    if (found.size() != 0) found[found.size() - 1].is_last = 1'b1;
    foreach (found[i]) expected_blocks.push_back(found[i]);
    upleft_px   = PIX_W'(up);
    left_px     = p;
    line_mem[x] = p;
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = x + 1;
      row_pos = r;
    end
  endfunction

  // any size write restarts the frame; neighbour registers are kept
  function void predict_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_WIDTH:  width_reg  = val;
      REG_HEIGHT: height_reg = val;
      default: return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blocks outstanding",
               cycle_count, expected_blocks.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: ready pacing with random stalls and the long hold-off.
  // The hold-off is counted here, in cycles, independent of the sender.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input upblock_t blk);
    if (got !== want)
      report_mismatch($sformatf("block (%0d,%0d) %s: got %0h, want %0h",
                                blk.row, blk.col, name, got, want));
  endtask

  // Output monitor: values read at the edge are the pre-edge ones, so a
  // transfer is exactly valid && ready as the design saw them.
  always @(posedge clk) begin
    upblock_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected block, tdata %0h", out_tdata));
      end else begin
        want = expected_blocks.pop_front();
        blocks_checked++;
        check_field("top_left",     16'(out_tdata[7:0]),   16'(want.tl),  want);
        check_field("top_right",    16'(out_tdata[15:8]),  16'(want.tr),  want);
        check_field("bottom_left",  16'(out_tdata[23:16]), 16'(want.bl),  want);
        check_field("bottom_right", 16'(out_tdata[31:24]), 16'(want.br),  want);
        check_field("source_row",   16'(out_tdata[41:32]), 16'(want.row), want);
        check_field("source_col",   16'(out_tdata[51:42]), 16'(want.col), want);
        check_field("padding",      16'(out_tdata[OUT_W-1:52]), 16'd0,    want);
        check_field("last_of_run",  16'(out_tlast),        16'(want.is_last), want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side helpers
  // --------------------------------------------------------------------------

  // Offer one pixel, with random idle cycles ahead of it, and hold until the
  // transfer. tvalid is left high afterwards, so back-to-back pixels never
  // drop it within a step.
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(p);
    do @(posedge clk); while (!in_tready);
    predict_pixel(p);
    pixels_sent++;
  endtask

  // Drop tvalid, let every predicted block drain, then allow for a pixel
  // still in flight that completes no block.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one register write; the trailing edge keeps cfg_we low for a step so a
  // following write never lowers and raises it within one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_cfg(idx, val);
    size_writes++;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // skewed towards black and white so saturation cases come up often
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset size is 512x512: a few pixels of the top row complete no block,
  // so any block here means the reset size is wrong.
  task automatic test_reset_size();
    repeat (RESET_ITEMS) send_pixel(rand_pixel());
  endtask

  // Small hand-built frames: every block kind, truncation, all-white sums,
  // single-pixel frames and zero sizes (which clamp to one).
  task automatic test_directed();
    logic [PIX_W-1:0] pat [6];
    pat = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    // 3x2: last pixel completes interior, right, bottom and corner blocks
    set_size(11'd3, 11'd2);
    foreach (pat[i]) send_pixel(pat[i]);
    // all white: largest four-way sum
    repeat (6) send_pixel(8'hFF);
    // zero width and height: 1x1, every pixel is its own corner block
    set_size(11'd0, 11'd0);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h01);
    // single column: right-edge block then corner on the bottom row
    set_size(11'd1, 11'd2);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(8'hFE);
    send_pixel(8'h03);
    // single row: bottom-edge and corner blocks along the row
    set_size(11'd2, 11'd1);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hC3);
    send_pixel(8'h3C);
  endtask

  // Oversized registers clamp to 1024: the start of a very wide single row
  // gives bottom-edge blocks only, the top of a very tall single column
  // gives right-edge blocks only.
  task automatic test_extreme_sizes();
    set_size(11'd2047, 11'd1);
    repeat (EDGE_ITEMS) send_pixel(rand_pixel());
    set_size(11'd1, 11'd2047);
    repeat (EDGE_ITEMS) send_pixel(rand_pixel());
  endtask

  // Output held off for a long stretch while pixels keep coming: the design
  // must fill, stall its input and then drain in order.
  task automatic test_backpressure();
    set_size(11'd5, 11'd4);
    hold_req <= hold_req + 1;
    repeat (40) send_pixel(rand_pixel());
  endtask

  // Random small frames. Mostly whole frames; some are cut short or run into
  // a second frame, and sometimes only one size register is rewritten.
  task automatic test_random_frames();
    int start;
    int frame;
    int n;
    int pick;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    start = pixels_sent;
    frame = 0;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      w = ($urandom_range(15) == 0) ? '0 : CFG_W'($urandom_range(1, 10));
      h = ($urandom_range(15) == 0) ? '0 : CFG_W'($urandom_range(1, 5));
      wait_idle();
      pick = $urandom_range(3);
      if (pick != 1 || frame == 0) write_reg(REG_WIDTH, w);
      if (pick != 0 || frame == 0) write_reg(REG_HEIGHT, h);
      n = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
      case ($urandom_range(7))
        0:       n = $urandom_range(1, n);   // broken frame
        1:       n = 2 * n;                  // runs into the next frame
        default: ;
      endcase
      // a run of frames with no idling at all on either side
      quiet <= (frame >= 8 && frame < 14);
      repeat (n) send_pixel(rand_pixel());
      frame++;
    end
    quiet <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    width_reg  = CFG_W'(RESET_SIZE);
    height_reg = CFG_W'(RESET_SIZE);
    row_pos    = 0;
    col_pos    = 0;
    left_px    = '0;
    upleft_px  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_directed();
    test_extreme_sizes();
    test_backpressure();
    test_random_frames();
    wait_idle();

    $display("%0d source pixels, %0d output blocks checked, %0d size writes",
             pixels_sent, blocks_checked, size_writes);
    $display("sizes from 1x1 (incl. zero) to clamped 1024, long output stall, random frames");
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/blu_pkg.sv
rtl/core/blu_ram.sv
rtl/core/blu_front.sv
rtl/core/blu_emit.sv
rtl/core/bilinear_upscale_2x.sv
rtl/core/blu_checker.sv
bench/bilinear_upscale_2x_tb.sv
